// ===== rtl/rfp_pkg.sv =====
// shared types, constants and the crc-8 step function of the range frame parser
package rfp_pkg;

  // frame geometry
  localparam int unsigned FRAME_BYTES   = 10;
  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned CNT_W         = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IDX_W         = $clog2(PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0] LEN_ONE  = CNT_W'(4);
  localparam logic [CNT_W-1:0] LEN_TWO  = CNT_W'(6);
  localparam logic [CNT_W-1:0] LEN_FULL = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] LAST_PAYLOAD_POS = CNT_W'(PAYLOAD_BYTES);

  // register map (word index taken from paddr[2])
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_CRC_POLY   = 1'b0;
  localparam logic REG_START_BYTE = 1'b1;

  // register reset values
  localparam logic [7:0] CRC_POLY_RST   = 8'h07;
  localparam logic [7:0] START_BYTE_RST = 8'h54;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ONE      = 2'd0,
    KIND_TWO      = 2'd1,
    KIND_FOUR     = 2'd2,
    KIND_CRC_FAIL = 2'd3
  } frame_kind_t;

  // one queued operation from the front to the back
  typedef struct packed {
    logic             store_en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic             emit;
    frame_kind_t      kind;
  } rfp_op_t;

  // crc-8, msb first, one byte folded in
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ poly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/rfp_front.sv =====
// front end: start hunt, byte count, running crc and frame classification
module rfp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      crc_poly,
  input  logic [7:0]      start_byte,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  output logic            op_valid,
  input  logic            op_ready,
  output rfp_pkg::rfp_op_t op
);
  import rfp_pkg::*;

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [CNT_W-1:0] len;
  logic             crc_ok;
  logic             accept;
  logic             want_push;

  assign in_ready = op_ready;
  assign accept   = in_valid && in_ready;
  assign len      = byte_count_r + CNT_W'(1);
  assign crc_ok   = (crc_r == in_rx_byte);

  // classify the byte and build the operation for the back end
  always_comb begin
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    want_push      = 1'b0;
    op.store_en    = 1'b0;
    op.idx         = IDX_W'(byte_count_r - CNT_W'(1));
    op.data        = in_rx_byte;
    op.emit        = 1'b0;
    op.kind        = KIND_ONE;
    if (byte_count_r == '0) begin
      // hunting for the start byte
      if (in_rx_byte == start_byte) begin
        crc_nxt        = crc8_fold(8'h00, in_rx_byte, crc_poly);
        byte_count_nxt = CNT_W'(1);
      end
    end else if (byte_count_r >= LEN_FULL) begin
      // resync to hunting
      byte_count_nxt = '0;
      crc_nxt        = '0;
    end else begin
      op.store_en    = (byte_count_r <= LAST_PAYLOAD_POS);
      crc_nxt        = crc8_fold(crc_r, in_rx_byte, crc_poly);
      byte_count_nxt = len;
      if (len == LEN_ONE && crc_ok) begin
        op.emit = 1'b1;
        op.kind = KIND_ONE;
      end else if (len == LEN_TWO && crc_ok) begin
        op.emit = 1'b1;
        op.kind = KIND_TWO;
      end else if (len == LEN_FULL) begin
        op.emit = 1'b1;
        op.kind = crc_ok ? KIND_FOUR : KIND_CRC_FAIL;
      end
      if (op.emit) begin
        byte_count_nxt = '0;
        crc_nxt        = '0;
      end
      want_push = op.store_en || op.emit;
    end
  end

  assign op_valid = in_valid && want_push;

  // frame tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      crc_r        <= '0;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
    end
  end

endmodule

// ===== rtl/rfp_queue.sv =====
// two-entry queue of operations between the front and the back end
module rfp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  rfp_pkg::rfp_op_t push_op,
  output logic             pop_valid,
  input  logic             pop_ready,
  output rfp_pkg::rfp_op_t pop_op
);
  import rfp_pkg::*;

  rfp_op_t     entries_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_op     = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/rfp_back.sv =====
// back end: payload byte store and registered result beat
module rfp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             op_valid,
  output logic             op_ready,
  input  rfp_pkg::rfp_op_t op,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_frame_kind,
  output logic [15:0]      out_dist_a,
  output logic [15:0]      out_dist_b,
  output logic [15:0]      out_dist_c,
  output logic [15:0]      out_dist_d
);
  import rfp_pkg::*;

  logic [7:0]  payload_r [PAYLOAD_BYTES];
  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [15:0] dist_a_r, dist_b_r, dist_c_r, dist_d_r;
  logic        take;

  // an emitting op waits for the output register to free up
  assign op_ready = !op.emit || !out_valid_r || out_ready;
  assign take     = op_valid && op_ready;

  // payload bytes of the current frame
  always_ff @(posedge clk) begin
    if (take && op.store_en) begin
      payload_r[op.idx] <= op.data;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && op.emit) begin
      kind_r <= op.kind;
      case (op.kind)
        KIND_ONE: begin
          dist_a_r <= {payload_r[0], payload_r[1]};
          dist_b_r <= '0;
          dist_c_r <= '0;
          dist_d_r <= '0;
        end
        KIND_TWO: begin
          dist_a_r <= {payload_r[0], payload_r[1]};
          dist_b_r <= {payload_r[2], payload_r[3]};
          dist_c_r <= '0;
          dist_d_r <= '0;
        end
        KIND_FOUR: begin
          dist_a_r <= {payload_r[0], payload_r[1]};
          dist_b_r <= {payload_r[2], payload_r[3]};
          dist_c_r <= {payload_r[4], payload_r[5]};
          dist_d_r <= {payload_r[6], payload_r[7]};
        end
        default: begin
          dist_a_r <= '0;
          dist_b_r <= '0;
          dist_c_r <= '0;
          dist_d_r <= '0;
        end
      endcase
    end
  end

  // result beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && op.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_kind = kind_r;
  assign out_dist_a     = dist_a_r;
  assign out_dist_b     = dist_b_r;
  assign out_dist_c     = dist_c_r;
  assign out_dist_d     = dist_d_r;

endmodule

// ===== rtl/range_frame_parser_crc8_top.sv =====
// top level of the serial range frame parser with crc-8 check
// Takes one received serial byte per beat, one beat every clock cycle. The
// front end hunts for the start byte, counts frame bytes and keeps a running
// crc-8 (msb first, initial value zero, polynomial from the crc_poly register);
// frame bytes and result requests go through a two-entry queue to the back
// end, which keeps frame bytes 1 to 8 and loads the output register. A result
// beat (one, two or four big-endian distances, or a crc failure at full
// length) passes from the queue entry to the output register after the byte
// that completes the frame. Input stalls only when the output register holds
// an untaken result and the queue has filled behind it. Registers: crc_poly at
// byte address 0 (reset 0x07), start_byte at byte address 4 (reset 0x54);
// write them only while the block is idle.
module range_frame_parser_crc8_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_kind,
  output logic [15:0] out_dist_a,
  output logic [15:0] out_dist_b,
  output logic [15:0] out_dist_c,
  output logic [15:0] out_dist_d
);
  import rfp_pkg::*;

  logic [7:0] crc_poly_r;
  logic [7:0] start_byte_r;
  logic       cfg_wr;
  rfp_op_t    front_op;
  logic       front_valid;
  logic       front_ready;
  rfp_op_t    back_op;
  logic       back_valid;
  logic       back_ready;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r   <= CRC_POLY_RST;
      start_byte_r <= START_BYTE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CRC_POLY:   crc_poly_r   <= pwdata[7:0];
        REG_START_BYTE: start_byte_r <= pwdata[7:0];
        default:        crc_poly_r   <= crc_poly_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_CRC_POLY:   prdata = {24'h0, crc_poly_r};
      REG_START_BYTE: prdata = {24'h0, start_byte_r};
      default:        prdata = '0;
    endcase
  end

  rfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .crc_poly   (crc_poly_r),
    .start_byte (start_byte_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .op_valid   (front_valid),
    .op_ready   (front_ready),
    .op         (front_op)
  );

  rfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_op    (front_op),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_op     (back_op)
  );

  rfp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_valid       (back_valid),
    .op_ready       (back_ready),
    .op             (back_op),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_kind (out_frame_kind),
    .out_dist_a     (out_dist_a),
    .out_dist_b     (out_dist_b),
    .out_dist_c     (out_dist_c),
    .out_dist_d     (out_dist_d)
  );

endmodule

// ===== sim/tb_top.sv =====
// testbench for the range frame parser: byte stimulus, result checking and register setup
`timescale 1ns / 100ps

module tb_top;
  import rfp_pkg::*;

  // one result beat as seen on the output channel
  typedef struct packed {
    frame_kind_t kind;
    logic [15:0] dist_a;
    logic [15:0] dist_b;
    logic [15:0] dist_c;
    logic [15:0] dist_d;
  } range_result_t;

  // frame parser prediction and result scoreboard
  class range_frame_tracker;
    logic [7:0]    poly;
    logic [7:0]    start_byte;
    logic [3:0]    byte_count;
    logic [7:0]    running_crc;
    logic [7:0]    payload [8];
    range_result_t expected_frames [$];
    int            error_count;
    int            kind_seen [4];

    function new();
      poly = CRC_POLY_RST;
      start_byte = START_BYTE_RST;
      byte_count = '0;
      running_crc = '0;
      error_count = 0;
      foreach (payload[i]) payload[i] = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    // crc-8 msb first over one byte with the current polynomial
    function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] acc;
      acc = crc ^ b;
      repeat (8) acc = acc[7] ? ((acc << 1) ^ poly) : (acc << 1);
      return acc;
    endfunction

    function logic [15:0] pair(input int idx);
      return {payload[idx], payload[idx+1]};
    endfunction

    function void set_reg(input logic idx, input logic [7:0] val);
      if (idx == REG_CRC_POLY) poly = val;
      else start_byte = val;
    endfunction

    // fold one accepted byte in; returns 1 when the byte belongs to a frame
    function bit note_byte(input logic [7:0] b);
      range_result_t r;
      logic [3:0]    len;
      bit            crc_match;
      if (byte_count == 0) begin
        if (b != start_byte) return 0;
        running_crc = crc_step(8'h00, b);
        byte_count = 4'd1;
        return 1;
      end
      if (byte_count <= LAST_PAYLOAD_POS) payload[byte_count - 1] = b;
      len = byte_count + 4'd1;
      crc_match = (running_crc == b);
      running_crc = crc_step(running_crc, b);
      byte_count = len;
      r = '0;
      if (len == LEN_ONE && crc_match) begin
        r.kind = KIND_ONE;
        r.dist_a = pair(0);
      end else if (len == LEN_TWO && crc_match) begin
        r.kind = KIND_TWO;
        r.dist_a = pair(0);
        r.dist_b = pair(2);
      end else if (len == LEN_FULL) begin
        if (crc_match) begin
          r.kind = KIND_FOUR;
          r.dist_a = pair(0);
          r.dist_b = pair(2);
          r.dist_c = pair(4);
          r.dist_d = pair(6);
        end else begin
          r.kind = KIND_CRC_FAIL;
        end
      end else begin
        return 1;
      end
      expected_frames.push_back(r);
      byte_count = '0;
      running_crc = '0;
      return 1;
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(input range_result_t got);
      range_result_t want;
      logic [15:0]   w [5];
      logic [15:0]   g [5];
      string         names [5];
      if (expected_frames.size() == 0) begin
        $error("unexpected result beat: frame_kind %0d dist_a %h", got.kind, got.dist_a);
        error_count++;
        return;
      end
      want = expected_frames.pop_front();
      kind_seen[want.kind]++;
      names = '{"frame_kind", "dist_a", "dist_b", "dist_c", "dist_d"};
      w = '{16'(want.kind), want.dist_a, want.dist_b, want.dist_c, want.dist_d};
      g = '{16'(got.kind), got.dist_a, got.dist_b, got.dist_c, got.dist_d};
      foreach (w[i]) begin
        if (w[i] !== g[i]) begin
          $error("%s: expected %h, got %h", names[i], w[i], g[i]);
          error_count++;
        end
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_frame_kind;
  logic [15:0] out_dist_a;
  logic [15:0] out_dist_b;
  logic [15:0] out_dist_c;
  logic [15:0] out_dist_d;

  range_frame_tracker frame_track = new();
  bit idle_on = 1'b1;
  int frame_bytes_sent = 0;
  int settings_used = 1;

  range_frame_parser_crc8_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_kind (out_frame_kind),
    .out_dist_a     (out_dist_a),
    .out_dist_b     (out_dist_b),
    .out_dist_c     (out_dist_c),
    .out_dist_d     (out_dist_d)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // overall time limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // data byte with extra weight on the extremes
  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one input beat, optionally after an idle burst; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    if (frame_track.note_byte(b)) frame_bytes_sent++;
    @(negedge clk);
  endtask

  // frame of 4, 6 or 10 bytes with the crc in its last byte, or a wrong one
  task automatic send_frame(input int len, input bit bad_crc, input bit use_fill,
                            input logic [7:0] fill);
    logic [7:0] fb [10];
    logic [7:0] crc;
    fb[0] = frame_track.start_byte;
    crc = frame_track.crc_step(8'h00, fb[0]);
    for (int k = 1; k < len; k++) begin
      if (k == len - 1) begin
        fb[k] = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
      end else begin
        fb[k] = use_fill ? fill : pick_data();
        // keep a longer frame from closing early at 4 or 6 bytes
        if ((k == 3 || k == 5) && fb[k] == crc) fb[k] = crc ^ 8'h01;
      end
      crc = frame_track.crc_step(crc, fb[k]);
    end
    for (int k = 0; k < len; k++) send_byte(fb[k]);
  endtask

  // hold the input until every expected result has been taken
  task automatic wait_drain();
    in_valid = 1'b0;
    while (frame_track.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // register write followed by a read back
  task automatic reg_write(input logic idx, input logic [7:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {24'h0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    frame_track.set_reg(idx, val);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== val) begin
      $error("register read back at %0d: expected %h, got %h", paddr, val, prdata[7:0]);
      frame_track.error_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // random traffic under one register setting
  task automatic run_phase(input int goal, input bit quiet);
    int  base;
    int  r;
    bit  drained;
    base = frame_bytes_sent;
    drained = 1'b0;
    while (frame_bytes_sent - base < goal) begin
      if (!quiet && $urandom_range(0, 7) == 0) idle_on = !idle_on;
      // pause the sender once mid-phase until the output side is empty
      if (!drained && frame_bytes_sent - base >= goal / 2) begin
        wait_drain();
        drained = 1'b1;
      end
      r = $urandom_range(0, 19);
      if (r < 14) begin
        case ($urandom_range(0, 2))
          0: send_frame(4, $urandom_range(0, 4) == 0, 1'b0, 8'h00);
          1: send_frame(6, $urandom_range(0, 4) == 0, 1'b0, 8'h00);
          default: send_frame(10, $urandom_range(0, 4) == 0, 1'b0, 8'h00);
        endcase
      end else if (r < 17) begin
        // cut-off frame: start byte and a few data bytes
        send_byte(frame_track.start_byte);
        repeat ($urandom_range(1, 8)) send_byte(pick_data());
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(pick_data());
      end
    end
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(0, 9);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // result beat check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      frame_track.check_result('{frame_kind_t'(out_frame_kind), out_dist_a, out_dist_b,
                                 out_dist_c, out_dist_d});
  end

  // main sequence
  initial begin
    logic [7:0] poly_set [6];
    logic [7:0] start_set [6];
    poly_set = '{8'h00, 8'hFF, 8'h31, 8'h00, 8'h00, CRC_POLY_RST};
    start_set = '{8'h00, 8'hFF, 8'hAA, 8'h00, 8'h00, START_BYTE_RST};
    for (int p = 3; p < 5; p++) begin
      poly_set[p] = 8'($urandom_range(0, 255));
      start_set[p] = 8'($urandom_range(0, 255));
    end
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: noise while hunting, all-ones distance, start byte as data, crc failure
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(4, 1'b0, 1'b1, 8'hFF);
    send_frame(6, 1'b0, 1'b1, START_BYTE_RST);
    send_frame(10, 1'b1, 1'b1, 8'h00);

    // random traffic under several register settings, the last without idling
    for (int p = 0; p < 6; p++) begin
      wait_drain();
      reg_write(REG_CRC_POLY, poly_set[p]);
      reg_write(REG_START_BYTE, start_set[p]);
      settings_used++;
      if (p == 5) idle_on = 1'b0;
      run_phase(120, p == 5);
    end

    wait_drain();
    repeat (20) @(negedge clk);
    $display("sent %0d frame bytes under %0d register settings", frame_bytes_sent,
             settings_used);
    $display("results: %0d one, %0d two, %0d four distances, %0d crc failures",
             frame_track.kind_seen[KIND_ONE], frame_track.kind_seen[KIND_TWO],
             frame_track.kind_seen[KIND_FOUR], frame_track.kind_seen[KIND_CRC_FAIL]);
    if (frame_track.error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
